// File: src/miu_pkg.sv
`default_nettype none
package miu_pkg;
	localparam int WORD_BITS = 32;

	localparam logic [5:0] OP_ADD = 6'd0, OP_ADDI = 6'd1, OP_ADDIU = 6'd2, OP_ADDU = 6'd3,
		OP_AND = 6'd4, OP_ANDI = 6'd5, OP_BEQ = 6'd6, OP_BGEZ = 6'd7, OP_BGTZ = 6'd8,
		OP_BLEZ = 6'd9, OP_BLTZ = 6'd10, OP_BNE = 6'd11, OP_DIV = 6'd12, OP_DIVU = 6'd13,
		OP_J = 6'd14, OP_JAL = 6'd15, OP_JALR = 6'd16, OP_JR = 6'd17, OP_LUI = 6'd18,
		OP_MFHI = 6'd19, OP_MFLO = 6'd20, OP_MTHI = 6'd21, OP_MTLO = 6'd22, OP_MUL = 6'd23,
		OP_MULT = 6'd24, OP_MULTU = 6'd25, OP_NOR = 6'd26, OP_OR = 6'd27, OP_ORI = 6'd28,
		OP_SLL = 6'd29, OP_SLLV = 6'd30, OP_SLT = 6'd31, OP_SLTI = 6'd32, OP_SLTIU = 6'd33,
		OP_SLTU = 6'd34, OP_SRA = 6'd35, OP_SRAV = 6'd36, OP_SRL = 6'd37, OP_SRLV = 6'd38,
		OP_SUB = 6'd39, OP_SUBU = 6'd40, OP_XOR = 6'd41, OP_XORI = 6'd42;

	localparam logic [1:0] DEST_NONE = 2'd0, DEST_RD = 2'd1, DEST_RT = 2'd2;
	localparam int LUI_SHIFT = 16;

	typedef struct packed {
		logic [5:0]  action;
		logic [31:0] rs_value;
		logic [31:0] rt_value;
		logic [4:0]  shift_amount;
		logic signed [15:0] immediate;
		logic [31:0] jump_target;
		logic [31:0] pc_now;
	} req_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic [1:0]  dest_kind;
		logic [31:0] next_pc;
		logic        branch_taken;
		logic        divide_by_zero;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic is_mul;
		logic is_signed;
	} seq_ctl_t;
endpackage
`default_nettype wire

// File: src/miu_if.sv
`default_nettype none
interface miu_req_if;
	logic valid;
	logic ready;
	miu_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface miu_rsp_if;
	logic valid;
	logic ready;
	miu_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/miu_muldiv.sv
`default_nettype none
// Shared shift/add-subtract unit: unsigned magnitudes, one bit per cycle.
// Multiply: acc = {P, multiplier}; divide: restoring, acc = {rem, quotient}.
module miu_muldiv (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire miu_pkg::seq_ctl_t ctl,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic        done,
	output logic [31:0] hi,
	output logic [31:0] lo
);
	logic [63:0] acc_q;
	logic [31:0] b_q;
	logic [5:0]  cnt_q;
	logic        busy_q, mul_q;
	logic [32:0] sum;
	logic [32:0] diff;
	logic [63:0] sh;

	always_comb begin
		sum  = {1'b0, acc_q[63:32]} + (acc_q[0] ? {1'b0, b_q} : 33'd0);
		sh   = {acc_q[62:0], 1'b0};
		// shifted remainder is 33 bits wide; its top bit is the one shifted out
		diff = {acc_q[63], sh[63:32]} - {1'b0, b_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			mul_q  <= 1'b0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			mul_q  <= ctl.is_mul;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd31) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= {32'd0, a};
			b_q   <= b;
		end else if (busy_q) begin
			if (mul_q) acc_q <= {sum, acc_q[31:1]};
			else if (!diff[32]) acc_q <= {diff[31:0], sh[31:1], 1'b1};
			else acc_q <= sh;
		end
	end

	assign done = busy_q && cnt_q == 6'd31;
	assign hi = acc_q[63:32];
	assign lo = acc_q[31:0];
endmodule
`default_nettype wire

// File: src/mips_integer_execute_unit.sv
`default_nettype none
// Integer execute unit for a MIPS32 subset holding HI/LO. One request in flight:
// ready only when idle, and the result register holds until taken. Ops other than
// multiply and divide go from IDLE through RUN to OUT: the result is registered at
// the end of RUN and is valid in OUT. mul/mult/multu/div/divu run through one shared
// shift/add-subtract unit: a start, then one bit per step, then a sign fix-up state
// (FIX) that writes HI/LO and the result before OUT. A zero divisor finishes like
// the other ops, straight from RUN to OUT, with the divide-by-zero flag set.
module mips_integer_execute_unit (
	input wire logic clk,
	input wire logic arst_n,
	miu_req_if.sink   req,
	miu_rsp_if.source rsp
);
	localparam logic [2:0] ST_IDLE = 3'd0, ST_RUN = 3'd1, ST_FIX = 3'd2, ST_OUT = 3'd3;
	logic [2:0] st_q;
	miu_pkg::req_t r_q;
	miu_pkg::rsp_t o_q;
	logic [miu_pkg::WORD_BITS-1:0] hi_q, lo_q;
	logic [31:0] rs, rt, imm_s, imm_z, ma, mb, res, npc, fhi, flo;
	logic [1:0] dest;
	logic take, cond, dz, sgn, na, nb, is_md, is_div, acc_req;
	logic [63:0] prod;
	miu_pkg::seq_ctl_t ctl;
	logic md_done;
	logic [31:0] md_hi, md_lo;
	logic md_busy_started_q;

	assign rs = r_q.rs_value;
	assign rt = r_q.rt_value;
	assign imm_s = {{16{r_q.immediate[15]}}, r_q.immediate};
	assign imm_z = {16'd0, r_q.immediate};
	assign is_div = r_q.action == miu_pkg::OP_DIV || r_q.action == miu_pkg::OP_DIVU;
	assign is_md = is_div || r_q.action == miu_pkg::OP_MUL || r_q.action == miu_pkg::OP_MULT
		|| r_q.action == miu_pkg::OP_MULTU;
	assign sgn = r_q.action == miu_pkg::OP_DIV || r_q.action == miu_pkg::OP_MUL
		|| r_q.action == miu_pkg::OP_MULT;
	assign na = sgn && rs[31];
	assign nb = sgn && rt[31];
	assign ma = na ? 32'd0 - rs : rs;
	assign mb = nb ? 32'd0 - rt : rt;
	assign dz = is_div && rt == 32'd0;
	assign acc_req = req.valid && req.ready;
	assign req.ready = st_q == ST_IDLE;

	// {start, is_mul, is_signed}
	assign ctl = {st_q == ST_RUN && is_md && !dz && !md_busy_started_q, !is_div, sgn};

	miu_muldiv u_md (.clk, .arst_n, .ctl, .a(ma), .b(mb), .done(md_done), .hi(md_hi),
		.lo(md_lo));

	// sign fix-up of magnitude results
	always_comb begin
		prod = {md_hi, md_lo};
		if (na != nb) prod = 64'd0 - prod;
		if (is_div) begin
			flo = (na != nb) ? 32'd0 - md_lo : md_lo;
			fhi = na ? 32'd0 - md_hi : md_hi;
		end else begin
			flo = prod[31:0];
			fhi = prod[63:32];
		end
	end

	always_comb begin
		res = '0; dest = miu_pkg::DEST_NONE; npc = r_q.pc_now; take = 1'b0; cond = 1'b0;
		case (r_q.action)
			miu_pkg::OP_ADD, miu_pkg::OP_ADDU: begin res = rs + rt; dest = miu_pkg::DEST_RD; end
			miu_pkg::OP_ADDI, miu_pkg::OP_ADDIU: begin res = rs + imm_s; dest = miu_pkg::DEST_RT; end
			miu_pkg::OP_AND: begin res = rs & rt; dest = miu_pkg::DEST_RD; end
			miu_pkg::OP_ANDI: begin res = rs & imm_z; dest = miu_pkg::DEST_RT; end
			miu_pkg::OP_BEQ: cond = rs == rt;
			miu_pkg::OP_BGEZ: cond = !rs[31];
			miu_pkg::OP_BGTZ: cond = !rs[31] && rs != 32'd0;
			miu_pkg::OP_BLEZ: cond = rs[31] || rs == 32'd0;
			miu_pkg::OP_BLTZ: cond = rs[31];
			miu_pkg::OP_BNE: cond = rs != rt;
			miu_pkg::OP_J, miu_pkg::OP_JAL: begin npc = r_q.jump_target; take = 1'b1; end
			miu_pkg::OP_JALR: begin
				res = r_q.pc_now; dest = miu_pkg::DEST_RD; npc = rs; take = 1'b1;
			end
			miu_pkg::OP_JR: begin npc = rs; take = 1'b1; end
			miu_pkg::OP_LUI: begin res = imm_z << miu_pkg::LUI_SHIFT; dest = miu_pkg::DEST_RT; end
			miu_pkg::OP_MFHI: begin res = hi_q; dest = miu_pkg::DEST_RD; end
			miu_pkg::OP_MFLO: begin res = lo_q; dest = miu_pkg::DEST_RD; end
			miu_pkg::OP_MUL: begin res = flo; dest = miu_pkg::DEST_RD; end
			miu_pkg::OP_NOR: begin res = ~(rs | rt); dest = miu_pkg::DEST_RD; end
			miu_pkg::OP_OR: begin res = rs | rt; dest = miu_pkg::DEST_RD; end
			miu_pkg::OP_ORI: begin res = rs | imm_z; dest = miu_pkg::DEST_RT; end
			miu_pkg::OP_SLL: begin res = rt << r_q.shift_amount; dest = miu_pkg::DEST_RD; end
			miu_pkg::OP_SLLV: begin res = rt << rs[4:0]; dest = miu_pkg::DEST_RD; end
			miu_pkg::OP_SLT: begin res = {31'd0, $signed(rs) < $signed(rt)}; dest = miu_pkg::DEST_RD; end
			miu_pkg::OP_SLTI: begin
				res = {31'd0, $signed(rs) < $signed(imm_s)}; dest = miu_pkg::DEST_RT;
			end
			miu_pkg::OP_SLTIU: begin res = {31'd0, rs < imm_s}; dest = miu_pkg::DEST_RT; end
			miu_pkg::OP_SLTU: begin res = {31'd0, rs < rt}; dest = miu_pkg::DEST_RD; end
			miu_pkg::OP_SRA: begin
				res = 32'($signed(rt) >>> r_q.shift_amount); dest = miu_pkg::DEST_RD;
			end
			miu_pkg::OP_SRAV: begin res = 32'($signed(rt) >>> rs[4:0]); dest = miu_pkg::DEST_RD; end
			miu_pkg::OP_SRL: begin res = rt >> r_q.shift_amount; dest = miu_pkg::DEST_RD; end
			miu_pkg::OP_SRLV: begin res = rt >> rs[4:0]; dest = miu_pkg::DEST_RD; end
			miu_pkg::OP_SUB, miu_pkg::OP_SUBU: begin res = rs - rt; dest = miu_pkg::DEST_RD; end
			miu_pkg::OP_XOR: begin res = rs ^ rt; dest = miu_pkg::DEST_RD; end
			miu_pkg::OP_XORI: begin res = rs ^ imm_z; dest = miu_pkg::DEST_RT; end
			default: ;
		endcase
		if (cond) begin
			npc = r_q.pc_now + imm_s - 32'd1;
			take = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			hi_q <= '0;
			lo_q <= '0;
			md_busy_started_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: if (acc_req) st_q <= ST_RUN;
				ST_RUN: begin
					if (!is_md || dz) begin
						st_q <= ST_OUT;
						if (r_q.action == miu_pkg::OP_MTHI) hi_q <= rs;
						if (r_q.action == miu_pkg::OP_MTLO) lo_q <= rs;
					end else begin
						md_busy_started_q <= 1'b1;
						if (md_done) st_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					md_busy_started_q <= 1'b0;
					hi_q <= fhi;
					lo_q <= flo;
					st_q <= ST_OUT;
				end
				ST_OUT: if (rsp.ready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_req) r_q <= req.payload;
		if ((st_q == ST_RUN && (!is_md || dz)) || st_q == ST_FIX) begin
			o_q.result_value <= res;
			o_q.dest_kind <= dest;
			o_q.next_pc <= npc;
			o_q.branch_taken <= take;
			o_q.divide_by_zero <= dz;
		end
	end

	assign rsp.valid = st_q == ST_OUT;
	assign rsp.payload = o_q;
endmodule
`default_nettype wire
